/* sv/rme_pkg.sv */
// ----------------------------------------------------------------------------
// rme_pkg: shared types and constants
// Widths and the CORDIC angle table for the rotation matrix to Euler block.
// ----------------------------------------------------------------------------
package rme_pkg;

  localparam int ElemW    = 16;
  // CORDIC vector width: 16-bit operand << 8, gain 1.65 and head room
  localparam int VecW     = 28;
  localparam int AngW     = 27;
  localparam int MaxSteps = 32;
  localparam int SqW      = 33;   // r00^2 + r10^2 fits in 32 bits unsigned
  localparam int RadW     = 48;   // radicand (sum << 16)
  localparam int RootW    = 24;

  localparam logic signed [AngW-1:0] Deg180 = AngW'(180 * 65536);

  typedef struct packed {
    logic signed [VecW-1:0] x;
    logic signed [VecW-1:0] y;
    logic signed [AngW-1:0] z;
    logic                   zero;
  } cordic_t;

  function automatic logic signed [AngW-1:0] atan_entry(input int unsigned i);
    logic signed [AngW-1:0] v;
    case (i)
      0: v = AngW'(2949120);  1: v = AngW'(1740967);  2: v = AngW'(919879);
      3: v = AngW'(466945);   4: v = AngW'(234379);   5: v = AngW'(117304);
      6: v = AngW'(58666);    7: v = AngW'(29335);    8: v = AngW'(14668);
      9: v = AngW'(7334);     10: v = AngW'(3667);    11: v = AngW'(1833);
      12: v = AngW'(917);     13: v = AngW'(458);     14: v = AngW'(229);
      15: v = AngW'(115);     16: v = AngW'(57);      17: v = AngW'(29);
      18: v = AngW'(14);      19: v = AngW'(7);       20: v = AngW'(4);
      21: v = AngW'(2);       22: v = AngW'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

/* sv/rme_isqrt.sv */
// ----------------------------------------------------------------------------
// rme_isqrt: pipelined integer square root
// One result bit per stage, restoring method, RootW stages.
// ----------------------------------------------------------------------------
module rme_isqrt (
  input  logic                       clk,
  input  logic                       en,
  input  logic [rme_pkg::RadW-1:0]   rad,
  output logic [rme_pkg::RootW-1:0]  root
);
  import rme_pkg::*;

  logic [RadW-1:0]  rem  [RootW+1];
  logic [RootW-1:0] res  [RootW+1];

  assign rem[0] = rad;
  assign res[0] = '0;

  for (genvar s = 0; s < RootW; s++) begin : g_stage
    localparam int B = RootW - 1 - s;
    logic [RadW-1:0]  trial;
    logic [RadW-1:0]  rem_q;
    logic [RootW-1:0] res_q;
    always_comb begin
      trial = (RadW'(res[s]) << (B + 1)) | (RadW'(1) << (2 * B));
    end
    always_ff @(posedge clk) begin
      if (en) begin
        if (rem[s] >= trial) begin
          rem_q <= rem[s] - trial;
          res_q <= res[s] | (RootW'(1) << B);
        end else begin
          rem_q <= rem[s];
          res_q <= res[s];
        end
      end
    end
    assign rem[s+1] = rem_q;
    assign res[s+1] = res_q;
  end

  assign root = res[RootW];
endmodule

/* sv/rme_cordic.sv */
// ----------------------------------------------------------------------------
// rme_cordic: pipelined vectoring CORDIC atan2
// Quadrant fold, one stage per iteration, rounding and clamp to Q8.7 degrees.
// ----------------------------------------------------------------------------
module rme_cordic #(
  parameter int STEPS = 16
) (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [rme_pkg::VecW-1:0]   y_in,
  input  logic signed [rme_pkg::VecW-1:0]   x_in,
  input  logic signed [15:0]                lim,
  output logic signed [15:0]                ang
);
  import rme_pkg::*;

  localparam int N = (STEPS < MaxSteps) ? STEPS : MaxSteps;

  cordic_t st [N+1];
  cordic_t pre;

  always_comb begin
    pre.zero = (x_in == '0) && (y_in == '0);
    if (x_in < 0) begin
      pre.x = -x_in;
      pre.y = -y_in;
      pre.z = (y_in >= 0) ? Deg180 : -Deg180;
    end else begin
      pre.x = x_in;
      pre.y = y_in;
      pre.z = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) st[0] <= pre;
  end

  for (genvar i = 0; i < N; i++) begin : g_it
    cordic_t nx;
    always_comb begin
      nx = st[i];
      if (st[i].y >= 0) begin
        nx.x = st[i].x + (st[i].y >>> i);
        nx.y = st[i].y - (st[i].x >>> i);
        nx.z = st[i].z + atan_entry(i);
      end else begin
        nx.x = st[i].x - (st[i].y >>> i);
        nx.y = st[i].y + (st[i].x >>> i);
        nx.z = st[i].z - atan_entry(i);
      end
    end
    always_ff @(posedge clk) begin
      if (en) st[i+1] <= nx;
    end
  end

  logic signed [AngW-1:0] rnd;
  logic signed [AngW-1:0] lim_w;
  logic signed [AngW-1:0] sel;
  always_comb begin
    rnd   = (st[N].z + AngW'(256)) >>> 9;
    lim_w = AngW'(lim);
    if (st[N].zero)        sel = '0;
    else if (rnd > lim_w)  sel = lim_w;
    else if (rnd < -lim_w) sel = -lim_w;
    else                   sel = rnd;
  end

  always_ff @(posedge clk) begin
    if (en) ang <= sel[15:0];
  end
endmodule

/* sv/rotation_matrix_to_euler.sv */
// ----------------------------------------------------------------------------
// rotation_matrix_to_euler: Z-Y-X Euler angles from a rotation matrix
// Input stream carries r00, r10, r20, r21, r22 (Q1.15) in one transfer; the
// output stream carries roll, pitch, yaw in Q8.7 degrees.
// Pitch runs a pipelined square root of r00^2 + r10^2 and then its own CORDIC
// lane; the roll and yaw operands are delayed so that all three CORDIC lanes
// start in the same cycle and the three angles leave together.
// Throughput: one transfer per cycle while m_axis does not stall. Stages in
// order: sum of squares, 24 root stages, quadrant fold, CORDIC stages,
// output; CORDIC_STEPS counts at most 32.
// The whole pipeline advances only when the output register is free or being
// taken, so a stall on m_axis holds every stage and loses nothing; s_axis
// tready is then low.
// Reset clears the valid bits only; data registers are not reset. s_axis
// tready is low during reset.
// ----------------------------------------------------------------------------
module rotation_matrix_to_euler #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // r00[15:0], r10[31:16], r20[47:32], r21[63:48], r22[79:64]
  input  logic [79:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // roll[15:0], pitch[30:16], yaw[46:31], zero fill [47]
  output logic [47:0] m_axis_tdata
);
  import rme_pkg::*;

  localparam int N   = (CORDIC_STEPS < MaxSteps) ? CORDIC_STEPS : MaxSteps;
  localparam int SQD = 1 + RootW;        // sum stage + root stages
  localparam int LAT = SQD + N + 2;      // + fold stage + output stage

  logic en;
  logic [LAT-1:0] vld;
  assign en = !m_axis_tvalid || m_axis_tready || !vld[LAT-1];
  assign s_axis_tready = en && !rst;

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[LAT-2:0], s_axis_tvalid};
  end
  assign m_axis_tvalid = vld[LAT-1];

  logic signed [15:0] r00, r10, r20, r21, r22;
  assign r00 = s_axis_tdata[15:0];
  assign r10 = s_axis_tdata[31:16];
  assign r20 = s_axis_tdata[47:32];
  assign r21 = s_axis_tdata[63:48];
  assign r22 = s_axis_tdata[79:64];

  // pitch path: sum of squares, root
  logic [SqW-1:0] sq;
  logic signed [16:0] nr20_q;
  always_ff @(posedge clk) begin
    if (en) begin
      sq     <= SqW'(32'(r00) * 32'(r00)) + SqW'(32'(r10) * 32'(r10));
      nr20_q <= -17'(r20);
    end
  end

  logic [RootW-1:0] h;
  rme_isqrt u_sqrt (
    .clk (clk), .en (en),
    .rad ({sq[RadW-17:0], 16'h0}),
    .root(h)
  );

  logic signed [16:0] nr20_d [RootW+1];
  assign nr20_d[0] = nr20_q;
  for (genvar k = 0; k < RootW; k++) begin : g_dly
    always_ff @(posedge clk) begin
      if (en) nr20_d[k+1] <= nr20_d[k];
    end
  end

  // roll/yaw inputs delayed to line up with the root
  logic signed [15:0] d21 [SQD+1], d22 [SQD+1], d10 [SQD+1], d00 [SQD+1];
  assign d21[0] = r21; assign d22[0] = r22;
  assign d10[0] = r10; assign d00[0] = r00;
  for (genvar k = 0; k < SQD; k++) begin : g_rdly
    always_ff @(posedge clk) begin
      if (en) begin
        d21[k+1] <= d21[k]; d22[k+1] <= d22[k];
        d10[k+1] <= d10[k]; d00[k+1] <= d00[k];
      end
    end
  end

  logic signed [15:0] roll, pitch, yaw;

  rme_cordic #(.STEPS(CORDIC_STEPS)) u_roll (
    .clk(clk), .en(en),
    .y_in(VecW'(d21[SQD]) <<< 8), .x_in(VecW'(d22[SQD]) <<< 8),
    .lim(16'sd23040), .ang(roll)
  );
  rme_cordic #(.STEPS(CORDIC_STEPS)) u_pitch (
    .clk(clk), .en(en),
    .y_in(VecW'(nr20_d[RootW]) <<< 8), .x_in(VecW'({1'b0, h})),
    .lim(16'sd11520), .ang(pitch)
  );
  rme_cordic #(.STEPS(CORDIC_STEPS)) u_yaw (
    .clk(clk), .en(en),
    .y_in(VecW'(d10[SQD]) <<< 8), .x_in(VecW'(d00[SQD]) <<< 8),
    .lim(16'sd23040), .ang(yaw)
  );

  assign m_axis_tdata = {1'b0, yaw, pitch[14:0], roll};
endmodule

/* test/rotation_matrix_to_euler_check.sv */
// ----------------------------------------------------------------------------
// rotation_matrix_to_euler_check: angle predictor and result checker
// Watches both streams, computes the expected roll, pitch and yaw for every
// accepted matrix and compares them in order with the block's results.
// ----------------------------------------------------------------------------
module rotation_matrix_to_euler_check #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [47:0] m_axis_tdata,
  output int          errors,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [15:0] yaw;
    logic [14:0] pitch;
    logic [15:0] roll;
  } angles_t;

  angles_t angle_fifo[$];
  longint  atan_tab[32] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
    58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7,
    4, 2, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0};

  function automatic longint shr_floor(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint isqrt_fast(longint n);
    longint lo = 0;
    longint hi = 64'd4294967296;
    longint mid;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      if (mid * mid <= n) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  function automatic longint atan2_deg(longint y, longint x, longint lim);
    longint z = 0;
    longint dx, dy, r;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      z = (y >= 0) ? 180 * 65536 : -180 * 65536;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < CORDIC_STEPS && i < 32; i++) begin
      dx = shr_floor(y, i);
      dy = shr_floor(x, i);
      if (y >= 0) begin
        x = x + dx; y = y - dy; z = z + atan_tab[i];
      end else begin
        x = x - dx; y = y + dy; z = z - atan_tab[i];
      end
    end
    r = shr_floor(z + 256, 9);
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r;
  endfunction

  function automatic angles_t euler_of(logic [79:0] d);
    longint r00, r10, r20, r21, r22, h;
    angles_t a;
    r00 = longint'($signed(d[15:0]));
    r10 = longint'($signed(d[31:16]));
    r20 = longint'($signed(d[47:32]));
    r21 = longint'($signed(d[63:48]));
    r22 = longint'($signed(d[79:64]));
    h = isqrt_fast((r00 * r00 + r10 * r10) * 65536);
    a.roll  = 16'(atan2_deg(r21 * 256, r22 * 256, 23040));
    a.pitch = 15'(atan2_deg(-r20 * 256, h, 11520));
    a.yaw   = 16'(atan2_deg(r10 * 256, r00 * 256, 23040));
    return a;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    errors++;
  endtask

  assign pending = angle_fifo.size();

  initial errors = 0;

  always @(posedge clk) begin
    angles_t w;
    angles_t g;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) angle_fifo.push_back(euler_of(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        g.roll  = m_axis_tdata[15:0];
        g.pitch = m_axis_tdata[30:16];
        g.yaw   = m_axis_tdata[46:31];
        if (angle_fifo.size() == 0) begin
          report("unexpected transfer", m_axis_tdata, 0);
        end else begin
          w = angle_fifo.pop_front();
          if (g.roll != w.roll)
            report("roll", $signed(g.roll), $signed(w.roll));
          if (g.pitch != w.pitch)
            report("pitch", $signed(g.pitch), $signed(w.pitch));
          if (g.yaw != w.yaw)
            report("yaw", $signed(g.yaw), $signed(w.yaw));
          if (m_axis_tdata[47] !== 1'b0)
            report("fill bit", m_axis_tdata[47], 0);
        end
      end
    end
  end
endmodule

/* test/rotation_matrix_to_euler_test.sv */
// ----------------------------------------------------------------------------
// rotation_matrix_to_euler_test: stimulus and verdict
// Feeds directed corner matrices, real rotations and random elements with
// random gaps and back pressure; the checker predicts and compares.
// ----------------------------------------------------------------------------
module rotation_matrix_to_euler_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Steps = 16;
  localparam int RandItems = 2000;
  localparam int IdleLimit = 5000;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;
  int          errors;
  int          pending;
  int          idle_cycles;
  bit          no_gaps;

  rotation_matrix_to_euler #(.CORDIC_STEPS(Steps)) i_dut (.*);

  rotation_matrix_to_euler_check #(.CORDIC_STEPS(Steps)) i_check (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // receiver back pressure
  always @(posedge clk) begin
    if (rst) m_axis_tready <= 1'b0;
    else m_axis_tready <= no_gaps || ($urandom_range(99) >= 28);
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IdleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic send(logic [15:0] a, logic [15:0] b, logic [15:0] c,
                      logic [15:0] d, logic [15:0] e);
    while (!no_gaps && $urandom_range(99) < 28) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {e, d, c, b, a};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  function automatic logic [15:0] q15(real v);
    longint t = longint'(v * 32768.0);
    if (t > 32767) t = 32767;
    if (t < -32768) t = -32768;
    return 16'(t);
  endfunction

  task automatic send_rotation(real yaw, real pitch, real roll);
    real cy, sy, cp, sp, cr, sr;
    cy = $cos(yaw); sy = $sin(yaw); cp = $cos(pitch); sp = $sin(pitch);
    cr = $cos(roll); sr = $sin(roll);
    send(q15(cy * cp), q15(sy * cp), q15(-sp), q15(cp * sr), q15(cp * cr));
  endtask

  function automatic logic [15:0] rand_elem();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'(int'($urandom_range(8)) - 4);
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    real pi;
    pi = 3.14159265358979;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    no_gaps = 1'b0;
    idle_cycles = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // corners: zero vectors, full scale, gimbal lock, quadrant boundaries
    send(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    send(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send(16'h0000, 16'h0000, 16'h8000, 16'h0000, 16'h0000);
    send(16'h0000, 16'h0000, 16'h7fff, 16'h0000, 16'h0000);
    send(16'h8000, 16'h0000, 16'h0000, 16'h0000, 16'h8000);
    send(16'h8000, 16'hffff, 16'h0001, 16'hffff, 16'h8000);
    send(16'h8000, 16'h0001, 16'hffff, 16'h0001, 16'h8000);
    send(16'h0000, 16'h7fff, 16'h0000, 16'h8000, 16'h0000);
    send(16'h0000, 16'h8000, 16'h0000, 16'h7fff, 16'h0000);
    send(16'h7fff, 16'h0000, 16'h0000, 16'h0000, 16'h7fff);
    send(16'h0001, 16'h0000, 16'h0000, 16'h0001, 16'h0001);
    send(16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555);
    send(16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa);
    send_rotation(pi / 4, pi / 6, -pi / 3);
    send_rotation(-3 * pi / 4, -pi / 2, pi);

    // drain before random traffic
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);

    for (int n = 0; n < RandItems; n++) begin
      no_gaps = (n >= 800 && n < 1100);
      if ($urandom_range(99) < 60)
        send_rotation(($urandom_range(20000) / 10000.0 - 1.0) * pi,
                      ($urandom_range(20000) / 10000.0 - 1.0) * pi / 2,
                      ($urandom_range(20000) / 10000.0 - 1.0) * pi);
      else
        send(rand_elem(), rand_elem(), rand_elem(), rand_elem(), rand_elem());
    end
    no_gaps = 1'b0;
    s_axis_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (Steps + 40) @(posedge clk);
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end
endmodule
